FILE: rtl/csa_pkg.sv
// Shared constants for the checked signed ALU: field widths, op and status codes.
package csa_pkg;

    localparam int unsigned WORD_W   = 64;
    localparam int unsigned OP_W     = 3;
    localparam int unsigned STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV = 3'd3;
    localparam logic [OP_W-1:0] OP_MOD = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZ  = 2'd3;

endpackage

FILE: rtl/csa_if.sv
// Valid/ready channel interfaces for the ALU request and response words.
interface csa_req_if
    import csa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] operand_a;
    logic [WORD_W-1:0] operand_b;

    modport source (output valid, output op, output operand_a, output operand_b, input ready);
    modport sink   (input valid, input op, input operand_a, input operand_b, output ready);
endinterface

interface csa_rsp_if
    import csa_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   value;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

FILE: rtl/checked_signed_alu.sv
// Pipelined overflow-checked signed ALU: add, subtract, multiply, divide, modulo.
// A request word passes stage registers 0 to DATA_WIDTH, then the output register.
// Throughput: one word per cycle unless stalled; the divider retires one quotient
// bit per stage, which sets the pipeline depth at DATA_WIDTH + 2 register stages.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// Reset (rst_n low, asynchronous) clears every stage valid bit; payload is not reset.
module checked_signed_alu
    import csa_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    csa_req_if.sink    req,
    csa_rsp_if.source  rsp
);

    localparam int unsigned W  = DATA_WIDTH;
    localparam int unsigned H  = (W + 1) / 2;
    localparam int unsigned L  = W - H;
    localparam int unsigned P2 = 2 * W;

    typedef struct packed {
        logic              vld;
        logic [OP_W-1:0]   op;
        logic              na;
        logic              nb;
        logic [W-1:0]      mb;
        logic [W-1:0]      aq;
        logic [W-1:0]      rem;
        logic [2*H-1:0]    pp_ll;
        logic [W-1:0]      pp_lh;
        logic [W-1:0]      pp_hl;
        logic [2*L-1:0]    pp_hh;
        logic [P2-1:0]     prod;
        logic [W:0]        addsum;
    } stage_t;

    stage_t stg_reg  [0:W];
    stage_t stg_next [0:W];
    logic [W:0] vld_vec;

    logic                out_vld_reg;
    logic [WORD_W-1:0]   out_value_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [WORD_W-1:0]   out_value_next;
    logic [STATUS_W-1:0] out_status_next;

    logic adv;

    assign adv       = !out_vld_reg || rsp.ready;
    assign req.ready = adv;

    // Input stage: split operands into sign and magnitude, do the exact add/sub.
    logic [W-1:0] a_w;
    logic [W-1:0] b_w;
    logic [W:0]   a_x;
    logic [W:0]   b_x;

    always_comb
    begin
        a_w = req.operand_a[W-1:0];
        b_w = req.operand_b[W-1:0];
        a_x = {a_w[W-1], a_w};
        b_x = {b_w[W-1], b_w};
        stg_next[0]        = '0;
        stg_next[0].vld    = req.valid;
        stg_next[0].op     = req.op;
        stg_next[0].na     = a_w[W-1];
        stg_next[0].nb     = b_w[W-1];
        stg_next[0].aq     = a_w[W-1] ? (W)'(-a_w) : a_w;
        stg_next[0].mb     = b_w[W-1] ? (W)'(-b_w) : b_w;
        stg_next[0].addsum = (req.op == OP_SUB) ? (W+1)'(a_x - b_x) : (W+1)'(a_x + b_x);
    end

    genvar k;
    generate
        for (k = 1; k <= W; k++)
        begin : g_stage
            logic [W:0] shifted;
            logic       ge;

            always_comb
            begin
                stg_next[k] = stg_reg[k-1];
                // one restoring-division step
                shifted = {stg_reg[k-1].rem, stg_reg[k-1].aq[W-1]};
                ge      = shifted >= {1'b0, stg_reg[k-1].mb};
                stg_next[k].rem = ge ? (W)'(shifted - {1'b0, stg_reg[k-1].mb})
                                     : shifted[W-1:0];
                stg_next[k].aq  = {stg_reg[k-1].aq[W-2:0], ge};
                if (k == 1)
                begin
                    stg_next[k].pp_ll = (2*H)'(stg_reg[k-1].aq[H-1:0])
                                      * (2*H)'(stg_reg[k-1].mb[H-1:0]);
                    stg_next[k].pp_lh = (W)'(stg_reg[k-1].aq[H-1:0])
                                      * (W)'(stg_reg[k-1].mb[W-1:H]);
                    stg_next[k].pp_hl = (W)'(stg_reg[k-1].aq[W-1:H])
                                      * (W)'(stg_reg[k-1].mb[H-1:0]);
                    stg_next[k].pp_hh = (2*L)'(stg_reg[k-1].aq[W-1:H])
                                      * (2*L)'(stg_reg[k-1].mb[W-1:H]);
                end
                if (k == 2)
                begin
                    stg_next[k].prod = (P2)'(stg_reg[k-1].pp_ll)
                                     + ((P2)'(stg_reg[k-1].pp_lh) << H)
                                     + ((P2)'(stg_reg[k-1].pp_hl) << H)
                                     + ((P2)'(stg_reg[k-1].pp_hh) << (2 * H));
                end
            end
        end

        for (k = 0; k <= W; k++)
        begin : g_vld
            assign vld_vec[k] = stg_reg[k].vld;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= W; i++)
            begin
                stg_reg[i].vld <= 1'b0;
            end
        end
        else if (adv)
        begin
            for (int i = 0; i <= W; i++)
            begin
                stg_reg[i] <= stg_next[i];
            end
        end
    end

    // Final stage: pick the result, check the range, zero on error.
    stage_t          fin;
    logic            neg;
    logic [P2-1:0]   lim;
    logic [W-1:0]    res;
    logic [STATUS_W-1:0] st;

    always_comb
    begin
        fin = stg_reg[W];
        neg = fin.na ^ fin.nb;
        lim = (P2)'({1'b1, {(W-1){1'b0}}}) - (P2)'(!neg);
        res = '0;
        st  = ST_OK;
        case (fin.op)
            OP_ADD, OP_SUB:
            begin
                res = fin.addsum[W-1:0];
                if (!fin.addsum[W] && fin.addsum[W-1])
                begin
                    st = ST_OVER;
                end
                else if (fin.addsum[W] && !fin.addsum[W-1])
                begin
                    st = ST_UNDER;
                end
            end
            OP_MUL:
            begin
                res = neg ? (W)'(-fin.prod[W-1:0]) : fin.prod[W-1:0];
                if (fin.prod > lim)
                begin
                    st = neg ? ST_UNDER : ST_OVER;
                end
            end
            OP_DIV:
            begin
                res = neg ? (W)'(-fin.aq) : fin.aq;
                if (fin.mb == '0)
                begin
                    st = ST_DIVZ;
                end
                else if (!neg && fin.aq[W-1])
                begin
                    st = ST_OVER;
                end
            end
            OP_MOD:
            begin
                res = (fin.na && fin.rem != '0) ? (W)'(fin.mb - fin.rem) : fin.rem;
                if (fin.mb == '0)
                begin
                    st = ST_DIVZ;
                end
            end
            default:
            begin
                res = '0;
                st  = ST_OK;
            end
        endcase
        if (st != ST_OK)
        begin
            res = '0;
        end
        out_value_next  = {{(WORD_W-W){res[W-1]}}, res};
        out_status_next = st;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= fin.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
        end
    end

    assign rsp.valid  = out_vld_reg;
    assign rsp.value  = out_value_reg;
    assign rsp.status = out_status_reg;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_OK |-> rsp.value == '0)
        else $error("non-ok status with nonzero value");

    a_sext: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.value[WORD_W-1:W-1] == {(WORD_W-W+1){rsp.value[W-1]}})
        else $error("value not sign extended");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_vec))
        else $error("pipeline moved during stall");

    a_divz: assert property (@(posedge clk) disable iff (!rst_n)
        adv && fin.vld && (fin.op == OP_DIV || fin.op == OP_MOD) && fin.mb == '0
        |=> rsp.status == ST_DIVZ)
        else $error("zero divisor not flagged");

endmodule
